// ----- hw/rtl/qtg_pkg.sv -----
`default_nettype none

package qtg_pkg;

   localparam int WIDE      = 232;
   localparam int COEFS     = 6;
   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 64;

   localparam logic [31:0] DURATION_RESET = 32'd655360;

   localparam logic OP_PLAN   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [3:0] {
      ACC_HOLD,
      ACC_LOAD_TWO,
      ACC_LOAD_Q,
      ACC_ADD_L,
      ACC_ADD_C,
      ACC_ABS,
      ACC_LOAD_DEN,
      ACC_MUL_START,
      ACC_MUL_STEP,
      ACC_DIV_START,
      ACC_DIV_STEP,
      ACC_LOAD_COEF,
      ACC_ADD_COEF
   } acc_op_type;

   typedef struct packed {
      logic       capture;
      acc_op_type acc_op;
      logic       den_load;
      logic [2:0] k;
      logic [1:0] d;
      logic       mem_we;
      logic       mem_re;
      logic       res_store;
      logic       res_fixed;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic axis_ok;
      logic past_end;
      logic rsp_busy;
   } status_type;

   function automatic logic [4:0] deriv_mult(input logic [1:0] d, input logic [2:0] k);
      logic [4:0] m;
      m = 5'd0;
      case (d)
         2'd0: m = 5'd1;
         2'd1: m = (k > 3'd5) ? 5'd0 : 5'(k);
         2'd2: begin
            case (k)
               3'd2:    m = 5'd2;
               3'd3:    m = 5'd6;
               3'd4:    m = 5'd12;
               3'd5:    m = 5'd20;
               default: m = 5'd0;
            endcase
         end
         default: m = 5'd0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/qtg_controller.sv -----
`default_nettype none

module qtg_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire qtg_pkg::status_type  status,
   output qtg_pkg::cmd_type          cmd
);

   typedef enum logic [18:0] {
      ST_IDLE     = 19'h00001,
      ST_DISPATCH = 19'h00002,
      ST_PWRLO    = 19'h00004,
      ST_PDEN     = 19'h00008,
      ST_MSTART   = 19'h00010,
      ST_MSTEP    = 19'h00020,
      ST_DENSAVE  = 19'h00040,
      ST_PLOADQ   = 19'h00080,
      ST_PADDL    = 19'h00100,
      ST_PADDC    = 19'h00200,
      ST_PABS     = 19'h00400,
      ST_DIVSTART = 19'h00800,
      ST_DIVSTEP  = 19'h01000,
      ST_PWRHI    = 19'h02000,
      ST_PNEXTDEN = 19'h04000,
      ST_SRD      = 19'h08000,
      ST_SADD     = 19'h10000,
      ST_SRES     = 19'h20000,
      ST_SOUT     = 19'h40000
   } state_type;

   typedef enum logic [4:0] {
      PH_DEN   = 5'b00001,
      PH_NUM1  = 5'b00010,
      PH_NUM2  = 5'b00100,
      PH_DENUP = 5'b01000,
      PH_EVAL  = 5'b10000
   } phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] d_ff, d_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] mcnt_ff, mcnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      k_in     = k_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      mcnt_in  = mcnt_ff;
      cmd        = '0;
      cmd.acc_op = qtg_pkg::ACC_HOLD;
      cmd.k      = k_ff;
      cmd.d      = d_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.op == qtg_pkg::OP_PLAN) begin
               k_in     = 3'd0;
               state_in = status.axis_ok ? ST_PWRLO : ST_IDLE;
            end else if (!status.axis_ok || status.past_end) begin
               cmd.res_fixed = 1'b1;
               state_in      = ST_SOUT;
            end else begin
               d_in     = 2'd0;
               k_in     = 3'd5;
               state_in = ST_SRD;
            end
         end
         ST_PWRLO: begin
            cmd.mem_we = 1'b1;
            if (k_ff == 3'd2) begin
               state_in = ST_PDEN;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_PDEN: begin
            cmd.acc_op = qtg_pkg::ACC_LOAD_TWO;
            mcnt_in    = 2'd0;
            phase_in   = PH_DEN;
            state_in   = ST_MSTART;
         end
         ST_MSTART: begin
            cmd.acc_op = qtg_pkg::ACC_MUL_START;
            cnt_in     = 6'd0;
            state_in   = ST_MSTEP;
         end
         ST_MSTEP: begin
            cmd.acc_op = qtg_pkg::ACC_MUL_STEP;
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff == 6'(qtg_pkg::MUL_STEPS - 1)) begin
               case (phase_ff)
                  PH_DEN: begin
                     if (mcnt_ff == 2'd2) begin
                        k_in     = 3'd3;
                        state_in = ST_DENSAVE;
                     end else begin
                        mcnt_in  = mcnt_ff + 2'd1;
                        state_in = ST_MSTART;
                     end
                  end
                  PH_NUM1:  state_in = ST_PADDL;
                  PH_NUM2:  state_in = ST_PADDC;
                  PH_DENUP: state_in = ST_DENSAVE;
                  PH_EVAL:  state_in = ST_SRD;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_DENSAVE: begin
            cmd.den_load = 1'b1;
            state_in     = ST_PLOADQ;
         end
         ST_PLOADQ: begin
            cmd.acc_op = qtg_pkg::ACC_LOAD_Q;
            phase_in   = PH_NUM1;
            state_in   = ST_MSTART;
         end
         ST_PADDL: begin
            cmd.acc_op = qtg_pkg::ACC_ADD_L;
            phase_in   = PH_NUM2;
            state_in   = ST_MSTART;
         end
         ST_PADDC: begin
            cmd.acc_op = qtg_pkg::ACC_ADD_C;
            state_in   = ST_PABS;
         end
         ST_PABS: begin
            cmd.acc_op = qtg_pkg::ACC_ABS;
            state_in   = ST_DIVSTART;
         end
         ST_DIVSTART: begin
            cmd.acc_op = qtg_pkg::ACC_DIV_START;
            cnt_in     = 6'd0;
            state_in   = ST_DIVSTEP;
         end
         ST_DIVSTEP: begin
            cmd.acc_op = qtg_pkg::ACC_DIV_STEP;
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff == 6'(qtg_pkg::DIV_STEPS - 1)) begin
               state_in = ST_PWRHI;
            end
         end
         ST_PWRHI: begin
            cmd.mem_we = 1'b1;
            if (k_ff == 3'd5) begin
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_PNEXTDEN;
            end
         end
         ST_PNEXTDEN: begin
            cmd.acc_op = qtg_pkg::ACC_LOAD_DEN;
            phase_in   = PH_DENUP;
            state_in   = ST_MSTART;
         end
         ST_SRD: begin
            cmd.mem_re = 1'b1;
            state_in   = ST_SADD;
         end
         ST_SADD: begin
            cmd.acc_op = (k_ff == 3'd5) ? qtg_pkg::ACC_LOAD_COEF : qtg_pkg::ACC_ADD_COEF;
            if (k_ff == 3'(d_ff)) begin
               state_in = ST_SRES;
            end else begin
               k_in     = k_ff - 3'd1;
               phase_in = PH_EVAL;
               state_in = ST_MSTART;
            end
         end
         ST_SRES: begin
            cmd.res_store = 1'b1;
            if (d_ff == 2'd2) begin
               state_in = ST_SOUT;
            end else begin
               d_in     = d_ff + 2'd1;
               k_in     = 3'd5;
               state_in = ST_SRD;
            end
         end
         ST_SOUT: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DEN;
         k_ff     <= 3'd0;
         d_ff     <= 2'd0;
         cnt_ff   <= 6'd0;
         mcnt_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
         d_ff     <= d_in;
         cnt_ff   <= cnt_in;
         mcnt_ff  <= mcnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/qtg_datapath.sv -----
`default_nettype none

module qtg_datapath #(
   parameter int AXES = 6
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire qtg_pkg::cmd_type    cmd,
   output qtg_pkg::status_type      status,
   input  wire logic                req_op,
   input  wire logic [2:0]          req_axis,
   input  wire logic signed [31:0]  req_start_pos,
   input  wire logic signed [31:0]  req_start_vel,
   input  wire logic signed [31:0]  req_start_accel,
   input  wire logic signed [31:0]  req_end_pos,
   input  wire logic signed [31:0]  req_end_vel,
   input  wire logic signed [31:0]  req_end_accel,
   input  wire logic [31:0]         req_sample_time,
   input  wire logic                csr_wr_en,
   input  wire logic [31:0]         csr_wr_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_out_axis,
   output logic signed [31:0]       rsp_position,
   output logic signed [31:0]       rsp_velocity,
   output logic signed [31:0]       rsp_acceleration
);

   localparam int W     = qtg_pkg::WIDE;
   localparam int DEPTH = AXES * qtg_pkg::COEFS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (AXES > 1) ? $clog2(AXES) : 1;

   typedef struct packed {
      logic               op;
      logic [2:0]         axis;
      logic signed [31:0] ps;
      logic signed [31:0] vs;
      logic signed [31:0] as;
      logic signed [31:0] pf;
      logic signed [31:0] vf;
      logic signed [31:0] af;
      logic [31:0]        tau;
   } item_type;

   item_type    item_ff, item_in;
   logic [31:0] dur_ff, dur_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] opnd_ff, opnd_in;
   logic [W-1:0] den_ff, den_in;
   logic [31:0] mier_ff, mier_in;
   logic [63:0] quo_ff, quo_in;
   logic        sign_ff, sign_in;
   logic [63:0] rd_ff;
   logic [31:0] hold_pos_ff, hold_pos_in;
   logic [31:0] hold_vel_ff, hold_vel_in;
   logic [31:0] hold_acc_ff, hold_acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_axis_ff, rsp_axis_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in;
   logic [31:0] rsp_vel_ff, rsp_vel_in;
   logic [31:0] rsp_acc_ff, rsp_acc_in;

   logic [63:0] coef_mem [DEPTH];
   logic [31:0] fpos_ff [AXES];

   logic [31:0]        eff_dur;
   logic               axis_ok;
   logic [6:0]         addr_full;
   logic [AW-1:0]      addr;
   logic [3:0]         axis_ext;
   logic [IW-1:0]      axis_idx;
   logic signed [39:0] ps_x, vs_x, as_x, pf_x, vf_x, af_x, dp_x;
   logic signed [39:0] c_co, l_co, q_co;
   logic [W-1:0]       num_sh, abs_val;
   logic               div_ge;
   logic [4:0]         mult;
   logic [71:0]        coef_x, coef_m;
   logic [W-1:0]       coef_sc;
   logic [W-1:0]       res_sh;
   logic [W-32:0]      res_top;
   logic [31:0]        res_sat;
   logic [63:0]        wdata;

   assign item_in = cmd.capture ?
      item_type'{req_op, req_axis, req_start_pos, req_start_vel, req_start_accel,
                 req_end_pos, req_end_vel, req_end_accel, req_sample_time} : item_ff;
   assign dur_in  = csr_wr_en ? csr_wr_data : dur_ff;
   assign eff_dur = (dur_ff == 32'd0) ? 32'd1 : dur_ff;

   assign axis_ok   = ({29'd0, item_ff.axis} < 32'(AXES));
   assign addr_full = 7'(item_ff.axis) * 7'd6 + 7'(cmd.k);
   assign addr      = addr_full[AW-1:0];
   assign axis_ext  = 4'(item_ff.axis);
   assign axis_idx  = axis_ext[IW-1:0];

   assign status.op       = item_ff.op;
   assign status.axis_ok  = axis_ok;
   assign status.past_end = (item_ff.tau > eff_dur);
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign ps_x = 40'(item_ff.ps);
   assign vs_x = 40'(item_ff.vs);
   assign as_x = 40'(item_ff.as);
   assign pf_x = 40'(item_ff.pf);
   assign vf_x = 40'(item_ff.vf);
   assign af_x = 40'(item_ff.af);
   assign dp_x = pf_x - ps_x;

   always_comb begin
      case (cmd.k)
         3'd3: begin
            c_co = 40'sd20 * dp_x;
            l_co = -(40'sd8 * vf_x + 40'sd12 * vs_x);
            q_co = -(40'sd3 * as_x - af_x);
         end
         3'd4: begin
            c_co = -(40'sd30 * dp_x);
            l_co = 40'sd14 * vf_x + 40'sd16 * vs_x;
            q_co = 40'sd3 * as_x - 40'sd2 * af_x;
         end
         default: begin
            c_co = 40'sd12 * dp_x;
            l_co = -(40'sd6 * vf_x + 40'sd6 * vs_x);
            q_co = -(as_x - af_x);
         end
      endcase
   end

   assign num_sh  = acc_ff << ({cmd.k, 4'b0} - 7'd16);
   assign abs_val = num_sh[W-1] ? (W'(0) - num_sh) : num_sh;
   assign div_ge  = (acc_ff >= opnd_ff);

   assign mult   = qtg_pkg::deriv_mult(cmd.d, cmd.k);
   assign coef_x = 72'($signed(rd_ff));
   always_comb begin
      coef_m = '0;
      for (int i = 0; i < 5; i++) begin
         if (mult[i]) coef_m = coef_m + (coef_x << i);
      end
   end
   assign coef_sc = W'($signed(coef_m)) << (7'd80 - {cmd.k, 4'b0});

   assign res_sh  = W'($signed(acc_ff) >>> (7'd96 - {1'b0, cmd.d, 4'b0}));
   assign res_top = res_sh[W-1:31];
   assign res_sat = ((&res_top) || !(|res_top)) ? res_sh[31:0] :
                    (res_sh[W-1] ? 32'h8000_0000 : 32'h7fff_ffff);

   always_comb begin
      case (cmd.k)
         3'd0: wdata = {{16{item_ff.ps[31]}}, item_ff.ps, 16'h0};
         3'd1: wdata = {{16{item_ff.vs[31]}}, item_ff.vs, 16'h0};
         3'd2: wdata = {{17{item_ff.as[31]}}, item_ff.as, 15'h0};
         default: begin
            if (quo_ff[63]) begin
               wdata = sign_ff ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            end else begin
               wdata = sign_ff ? (64'd0 - quo_ff) : quo_ff;
            end
         end
      endcase
   end

   always_comb begin
      acc_in  = acc_ff;
      opnd_in = opnd_ff;
      mier_in = mier_ff;
      quo_in  = quo_ff;
      sign_in = sign_ff;
      den_in  = cmd.den_load ? acc_ff : den_ff;
      case (cmd.acc_op)
         qtg_pkg::ACC_LOAD_TWO: acc_in = W'(2);
         qtg_pkg::ACC_LOAD_Q:   acc_in = W'(q_co);
         qtg_pkg::ACC_ADD_L:    acc_in = acc_ff + (W'(l_co) << 16);
         qtg_pkg::ACC_ADD_C:    acc_in = acc_ff + (W'(c_co) << 32);
         qtg_pkg::ACC_ABS: begin
            acc_in  = abs_val;
            sign_in = num_sh[W-1];
         end
         qtg_pkg::ACC_LOAD_DEN: acc_in = den_ff;
         qtg_pkg::ACC_MUL_START: begin
            opnd_in = acc_ff;
            acc_in  = '0;
            mier_in = (item_ff.op == qtg_pkg::OP_SAMPLE) ? item_ff.tau : eff_dur;
         end
         qtg_pkg::ACC_MUL_STEP: begin
            acc_in  = (acc_ff << 1) + (mier_ff[31] ? opnd_ff : W'(0));
            mier_in = mier_ff << 1;
         end
         qtg_pkg::ACC_DIV_START: begin
            opnd_in = den_ff << 63;
            quo_in  = '0;
         end
         qtg_pkg::ACC_DIV_STEP: begin
            if (div_ge) acc_in = acc_ff - opnd_ff;
            quo_in  = {quo_ff[62:0], div_ge};
            opnd_in = opnd_ff >> 1;
         end
         qtg_pkg::ACC_LOAD_COEF: acc_in = coef_sc;
         qtg_pkg::ACC_ADD_COEF:  acc_in = acc_ff + coef_sc;
         default: ;
      endcase
   end

   always_comb begin
      hold_pos_in = hold_pos_ff;
      hold_vel_in = hold_vel_ff;
      hold_acc_in = hold_acc_ff;
      if (cmd.res_fixed) begin
         hold_pos_in = axis_ok ? fpos_ff[axis_idx] : 32'd0;
         hold_vel_in = 32'd0;
         hold_acc_in = 32'd0;
      end else if (cmd.res_store) begin
         case (cmd.d)
            2'd0:    hold_pos_in = res_sat;
            2'd1:    hold_vel_in = res_sat;
            default: hold_acc_in = res_sat;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_acc_in   = rsp_acc_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_axis_in  = item_ff.axis;
         rsp_pos_in   = hold_pos_ff;
         rsp_vel_in   = hold_vel_ff;
         rsp_acc_in   = hold_acc_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff       <= qtg_pkg::DURATION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         dur_ff       <= dur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      acc_ff      <= acc_in;
      opnd_ff     <= opnd_in;
      den_ff      <= den_in;
      mier_ff     <= mier_in;
      quo_ff      <= quo_in;
      sign_ff     <= sign_in;
      hold_pos_ff <= hold_pos_in;
      hold_vel_ff <= hold_vel_in;
      hold_acc_ff <= hold_acc_in;
      rsp_axis_ff <= rsp_axis_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) coef_mem[addr] <= wdata;
      if (cmd.mem_re) rd_ff <= coef_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we && cmd.k == 3'd0) fpos_ff[axis_idx] <= item_ff.pf;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_axis     = rsp_axis_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_velocity     = rsp_vel_ff;
   assign rsp_acceleration = rsp_acc_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/quintic_trajectory_generator.sv -----
// Quintic trajectory generator, one polynomial per axis.
// req_*: valid/ready channel. op = 0 plans an axis from start/end position,
//   velocity and acceleration over csr duration; no response beat follows.
//   op = 1 samples an axis at sample_time; one rsp_* beat follows.
// csr_wr_en/csr_wr_data: duration, unsigned Q16.16; write only while idle.
// A plan beat runs eleven shift-add multiplies and three restoring divides
//   on one shared wide accumulator. A sample beat runs twelve multiplies
//   of Horner evaluation plus one coefficient read per term; past the end
//   or on an absent axis it skips the evaluation and answers directly.
// Throughput: one item at a time; req_ready is high only while idle.
// The response sits in an output register: the next item is accepted while
//   it waits, and a finished sample holds until the register is free.
// Reset: synchronous, active high; clears control, drops any pending beat,
//   loads duration with 10 s. Coefficient storage is not cleared; sample
//   only axes already planned.
`default_nettype none

module quintic_trajectory_generator #(
   parameter int AXES = 6
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_op,
   input  wire logic [2:0]         req_axis,
   input  wire logic signed [31:0] req_start_pos,
   input  wire logic signed [31:0] req_start_vel,
   input  wire logic signed [31:0] req_start_accel,
   input  wire logic signed [31:0] req_end_pos,
   input  wire logic signed [31:0] req_end_vel,
   input  wire logic signed [31:0] req_end_accel,
   input  wire logic [31:0]        req_sample_time,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_out_axis,
   output logic signed [31:0]      rsp_position,
   output logic signed [31:0]      rsp_velocity,
   output logic signed [31:0]      rsp_acceleration,
   input  wire logic               csr_wr_en,
   input  wire logic [31:0]        csr_wr_data
);

   qtg_pkg::cmd_type    cmd;
   qtg_pkg::status_type status;

   qtg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   qtg_datapath #(.AXES(AXES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_axis         (req_axis),
      .req_start_pos    (req_start_pos),
      .req_start_vel    (req_start_vel),
      .req_start_accel  (req_start_accel),
      .req_end_pos      (req_end_pos),
      .req_end_vel      (req_end_vel),
      .req_end_accel    (req_end_accel),
      .req_sample_time  (req_sample_time),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_axis     (rsp_out_axis),
      .rsp_position     (rsp_position),
      .rsp_velocity     (rsp_velocity),
      .rsp_acceleration (rsp_acceleration)
   );

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid && !rsp_ready))
      else $error("pending response overwritten");

   a_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> !req_ready)
      else $error("coefficient write while idle");

endmodule

`default_nettype wire
